// File: sv/hes_pkg.sv
// Package: shared types, widths, constants and the saturating adder of the Heston path step.
`default_nettype none
package hes_pkg;

  localparam int FRAC_BITS   = 24;
  localparam int STATE_WIDTH = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 47;

  // digit-by-digit root: radicand is the state value shifted up by the fraction
  localparam int ROOT_W   = (STATE_WIDTH + FRAC_BITS + 1) / 2;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int ITER_MAX = (STATE_WIDTH > ROOT_W) ? STATE_WIDTH : ROOT_W;
  localparam int CNT_W    = $clog2(ITER_MAX + 1);
  localparam int PROD_W   = 2 * STATE_WIDTH;
  localparam int SUM_W    = STATE_WIDTH + 2;
  localparam int CMP_W    = ((PROD_W + 1) > (ROOT_W + 1)) ? (PROD_W + 1) : (ROOT_W + 1);

  typedef logic signed [STATE_WIDTH-1:0] state_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  localparam state_t SMAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam state_t SMIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
  localparam state_t ONE  = state_t'(1) <<< FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_PRICE    = 3'd0,
    CFG_START_VARIANCE = 3'd1,
    CFG_DRIFT_RATE     = 3'd2,
    CFG_REV_LEVEL      = 3'd3,
    CFG_REV_SPEED      = 3'd4,
    CFG_VOL_OF_VOL     = 3'd5,
    CFG_CORRELATION    = 3'd6,
    CFG_STEP_SIZE      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic               start_path;
    logic signed [31:0] dw_price;
    logic signed [31:0] dw_variance;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] price;
    logic signed [47:0] variance;
    logic               variance_clamped;
  } out_item_t;

  // command to and response from the shared arithmetic unit
  typedef struct packed {
    logic   go;
    logic   is_root;
    state_t a;
    state_t b;
  } unit_cmd_t;

  typedef struct packed {
    logic   done;
    state_t res;
  } unit_rsp_t;

  function automatic state_t sat_add(state_t x, state_t y, logic neg_y);
    sum_t xe;
    sum_t ye;
    sum_t s;
    xe = sum_t'(x);
    ye = neg_y ? -sum_t'(y) : sum_t'(y);
    s  = xe + ye;
    if (s > sum_t'(SMAX)) return SMAX;
    if (s < sum_t'(SMIN)) return SMIN;
    return state_t'(s);
  endfunction

endpackage
`default_nettype wire

// File: sv/hes_unit.sv
// Shared arithmetic unit: bit-serial rounded fixed-point multiply and digit-by-digit square root.
`default_nettype none
module hes_unit import hes_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  unit_cmd_t cmd_i,
  output unit_rsp_t rsp_o
);

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_ROOT, U_FIN} uphase_e;

  uphase_e                  phase_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     root_op_q;
  logic                     neg_q;
  logic [PROD_W-1:0]        mcand_q;
  logic [STATE_WIDTH-1:0]   mplier_q;
  logic [PROD_W-1:0]        acc_q;
  logic [RAD_W-1:0]         rad_q;
  logic [ROOT_W:0]          rem_q;
  logic [ROOT_W-1:0]        root_q;
  logic                     done_q;
  state_t                   res_q;

  logic [STATE_WIDTH-1:0] mag_a;
  logic [STATE_WIDTH-1:0] mag_b;
  logic [ROOT_W+2:0]      rem_sh;
  logic [ROOT_W+2:0]      trial;
  logic                   ge;
  logic [CMP_W-1:0]       rnd;
  logic [CMP_W-1:0]       lim;
  logic [CMP_W-1:0]       mval;
  logic [CMP_W-1:0]       root_ext;
  state_t                 mul_res;
  state_t                 root_res;

  assign mag_a = cmd_i.a[STATE_WIDTH-1] ? -cmd_i.a : cmd_i.a;
  assign mag_b = cmd_i.b[STATE_WIDTH-1] ? -cmd_i.b : cmd_i.b;

  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = (ROOT_W+3)'({root_q, 2'b01});
  assign ge     = (rem_sh >= trial);

  always_comb begin
    rnd  = (CMP_W'(acc_q) + (CMP_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim  = CMP_W'(SMAX) + CMP_W'(neg_q);
    mval = (rnd > lim) ? lim : rnd;
    mul_res = neg_q ? -state_t'(mval[STATE_WIDTH-1:0]) : state_t'(mval[STATE_WIDTH-1:0]);
    root_ext = CMP_W'(root_q);
    root_res = (root_ext > CMP_W'(SMAX)) ? SMAX : state_t'(root_ext[STATE_WIDTH-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= U_IDLE;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      root_op_q <= 1'b0;
    end else begin
      // pulse done for one cycle after the final phase
      done_q <= (phase_q == U_FIN);
      unique case (phase_q)
        U_IDLE: begin
          if (cmd_i.go) begin
            cnt_q     <= '0;
            root_op_q <= cmd_i.is_root;
            neg_q     <= cmd_i.a[STATE_WIDTH-1] ^ cmd_i.b[STATE_WIDTH-1];
            mcand_q   <= PROD_W'(mag_a);
            mplier_q  <= mag_b;
            acc_q     <= '0;
            rem_q     <= '0;
            root_q    <= '0;
            // root of max(a,0): the radicand carries the fraction twice
            rad_q     <= (cmd_i.a > 0) ? (RAD_W'(cmd_i.a) << FRAC_BITS) : '0;
            phase_q   <= cmd_i.is_root ? U_ROOT : U_MUL;
          end
        end
        U_MUL: begin
          if (mplier_q[0]) acc_q <= acc_q + mcand_q;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          cnt_q    <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(STATE_WIDTH - 1)) phase_q <= U_FIN;
        end
        U_ROOT: begin
          rem_q  <= ge ? (ROOT_W+1)'(rem_sh - trial) : (ROOT_W+1)'(rem_sh);
          root_q <= {root_q[ROOT_W-2:0], ge};
          rad_q  <= rad_q << 2;
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(ROOT_W - 1)) phase_q <= U_FIN;
        end
        U_FIN: begin
          res_q   <= root_op_q ? root_res : mul_res;
          phase_q <= U_IDLE;
        end
        default: phase_q <= U_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule
`default_nettype wire

// File: sv/heston_euler_path_step.sv
// Top level: Heston stochastic-volatility path, one Euler step per input item.
// Usage:
//   Write the eight parameters on the configuration channel (cfg_valid_i,
//   cfg_index_i, cfg_data_i); cfg_ready_o is always high. Write only while idle.
//   Each input item (in_valid_i, in_stall_o, in_data_i) carries two Brownian
//   increments and a start flag; a set start flag reloads price and variance
//   from the start registers (saturated) before stepping.
//   One result item per input item leaves on out_valid_o / out_data_o and is
//   taken at an edge where out_stall_i is low.
// Sequencing:
//   One shared unit does all eleven products and both roots in turn. An item
//   is worked through from acceptance to the result register before the
//   next one is taken; in_stall_o is high for that whole time.
// Reset:
//   rst_ni clears the parameters, the path state and the output valid.
// Stall:
//   A held result does not block the next item; only when a new result is
//   ready while the old one still waits does the block hold in its last state.
`default_nettype none
module heston_euler_path_step import hes_pkg::*; (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output out_item_t             out_data_o
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FIN} state_e;

  // one step per operation of the shared unit, in issue order
  typedef enum logic [3:0] {
    ST_ROOT_V, ST_RHO_SQ, ST_ROOT_C, ST_C_DW1, ST_RHO_DW2, ST_P_R, ST_DRIFT_DT,
    ST_P_S, ST_DIFF_MIX, ST_LAMBDA_V, ST_REV_DT, ST_SIGV_S, ST_DIFF_DW2
  } step_e;

  // parameters
  logic [46:0]        start_price_q;
  logic [46:0]        start_var_q;
  logic signed [31:0] drift_q;
  logic signed [31:0] alpha_q;
  logic signed [31:0] lambda_q;
  logic signed [31:0] sigv_q;
  logic signed [25:0] rho_q;
  logic [30:0]        dt_q;

  state_e    state_q;
  step_e     step_q;
  state_t    p_q, v_q;
  state_t    np_q, nv_q;
  state_t    s_q, c_q, mix_q, tmp_q;
  state_t    dw1_q, dw2_q;
  logic      clamped_q;
  logic      out_valid_q;
  out_item_t out_q;

  unit_cmd_t cmd;
  unit_rsp_t rsp;

  state_t r_s, alpha_s, lambda_s, sigv_s, rho_s, dt_s;
  state_t load_p, load_v, cur_v;
  state_t add_x;
  logic   add_neg;
  state_t add_sum;
  logic   in_acc;
  logic   out_free;

  assign r_s      = state_t'(drift_q);
  assign alpha_s  = state_t'(alpha_q);
  assign lambda_s = state_t'(lambda_q);
  assign sigv_s   = state_t'(sigv_q);
  assign rho_s    = state_t'(rho_q);
  assign dt_s     = state_t'({1'b0, dt_q});

  // saturate reload values to the state range
  assign load_p = (CMP_W'(start_price_q) > CMP_W'(SMAX)) ? SMAX
                                                         : state_t'(start_price_q);
  assign load_v = (CMP_W'(start_var_q) > CMP_W'(SMAX)) ? SMAX
                                                       : state_t'(start_var_q);
  assign cur_v  = in_data_i.start_path ? load_v : v_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_price_q <= '0;
      start_var_q   <= '0;
      drift_q       <= '0;
      alpha_q       <= '0;
      lambda_q      <= '0;
      sigv_q        <= '0;
      rho_q         <= '0;
      dt_q          <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START_PRICE:    start_price_q <= cfg_data_i[46:0];
        CFG_START_VARIANCE: start_var_q   <= cfg_data_i[46:0];
        CFG_DRIFT_RATE:     drift_q       <= cfg_data_i[31:0];
        CFG_REV_LEVEL:      alpha_q       <= cfg_data_i[31:0];
        CFG_REV_SPEED:      lambda_q      <= cfg_data_i[31:0];
        CFG_VOL_OF_VOL:     sigv_q        <= cfg_data_i[31:0];
        CFG_CORRELATION:    rho_q         <= cfg_data_i[25:0];
        CFG_STEP_SIZE:      dt_q          <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // operand selection for the shared unit
  always_comb begin
    cmd.go      = (state_q == S_ISSUE);
    cmd.is_root = 1'b0;
    cmd.a       = '0;
    cmd.b       = '0;
    unique case (step_q)
      ST_ROOT_V:   begin cmd.is_root = 1'b1; cmd.a = v_q; end
      ST_RHO_SQ:   begin cmd.a = rho_s;    cmd.b = rho_s;  end
      ST_ROOT_C:   begin cmd.is_root = 1'b1; cmd.a = tmp_q; end
      ST_C_DW1:    begin cmd.a = c_q;      cmd.b = dw1_q;  end
      ST_RHO_DW2:  begin cmd.a = rho_s;    cmd.b = dw2_q;  end
      ST_P_R:      begin cmd.a = p_q;      cmd.b = r_s;    end
      ST_DRIFT_DT: begin cmd.a = tmp_q;    cmd.b = dt_s;   end
      ST_P_S:      begin cmd.a = p_q;      cmd.b = s_q;    end
      ST_DIFF_MIX: begin cmd.a = tmp_q;    cmd.b = mix_q;  end
      ST_LAMBDA_V: begin cmd.a = lambda_s; cmd.b = v_q;    end
      ST_REV_DT:   begin cmd.a = tmp_q;    cmd.b = dt_s;   end
      ST_SIGV_S:   begin cmd.a = sigv_s;   cmd.b = s_q;    end
      ST_DIFF_DW2: begin cmd.a = tmp_q;    cmd.b = dw2_q;  end
      default: ;
    endcase
  end

  // writeback adder: one saturating add per step, result of the unit as addend
  always_comb begin
    add_x   = '0;
    add_neg = 1'b0;
    unique case (step_q)
      ST_RHO_SQ:   begin add_x = ONE; add_neg = 1'b1; end
      ST_RHO_DW2:  add_x = tmp_q;
      ST_DRIFT_DT: add_x = p_q;
      ST_DIFF_MIX: add_x = np_q;
      ST_LAMBDA_V: begin add_x = alpha_s; add_neg = 1'b1; end
      ST_REV_DT:   add_x = v_q;
      ST_DIFF_DW2: add_x = nv_q;
      default: ;
    endcase
    add_sum = sat_add(add_x, rsp.res, add_neg);
  end

  hes_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= ST_ROOT_V;
      p_q         <= '0;
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // drop a taken result unless a new one replaces it this cycle
      if (out_valid_q && !out_stall_i && (state_q != S_FIN)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            // reload the path on start, then latch the drivers
            if (in_data_i.start_path) begin
              p_q <= load_p;
              v_q <= load_v;
            end
            clamped_q <= cur_v[STATE_WIDTH-1];
            dw1_q     <= state_t'(in_data_i.dw_price);
            dw2_q     <= state_t'(in_data_i.dw_variance);
            step_q    <= ST_ROOT_V;
            state_q   <= S_ISSUE;
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (rsp.done) begin
            unique case (step_q)
              ST_ROOT_V:   s_q   <= rsp.res;
              ST_RHO_SQ:   tmp_q <= add_sum[STATE_WIDTH-1] ? '0 : add_sum;
              ST_ROOT_C:   c_q   <= rsp.res;
              ST_C_DW1:    tmp_q <= rsp.res;
              ST_RHO_DW2:  mix_q <= add_sum;
              ST_P_R:      tmp_q <= rsp.res;
              ST_DRIFT_DT: np_q  <= add_sum;
              ST_P_S:      tmp_q <= rsp.res;
              ST_DIFF_MIX: np_q  <= add_sum;
              ST_LAMBDA_V: tmp_q <= add_sum;
              ST_REV_DT:   nv_q  <= add_sum;
              ST_SIGV_S:   tmp_q <= rsp.res;
              ST_DIFF_DW2: nv_q  <= add_sum;
              default: ;
            endcase
            if (step_q == ST_DIFF_DW2) begin
              state_q <= S_FIN;
            end else begin
              step_q  <= step_e'(step_q + 1'b1);
              state_q <= S_ISSUE;
            end
          end
        end
        S_FIN: begin
          // hold here while the previous result still waits
          if (out_free) begin
            p_q <= np_q;
            v_q <= nv_q;
            out_q.price            <= np_q[47:0];
            out_q.variance         <= nv_q[47:0];
            out_q.variance_clamped <= clamped_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result valid raised outside the final state");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == S_WAIT))
    else $error("unit finished while the sequencer was not waiting");

  a_go_unit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE) |=> (state_q == S_WAIT) && !rsp.done)
    else $error("issue not followed by a wait");

  a_accept_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_ISSUE) && (step_q == ST_ROOT_V))
    else $error("accepted item did not start at the first step");

endmodule
`default_nettype wire

// File: tb/heston_euler_path_step_checker.sv
// Checker: watches the Heston step channels, predicts each result item and compares.
`timescale 1ns / 100ps
module heston_euler_path_step_checker import hes_pkg::*; (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_valid_i,
  input  wire                  cfg_ready_i,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i,
  input  wire                  in_valid_i,
  input  wire                  in_stall_i,
  input  in_item_t             in_data_i,
  input  wire                  out_valid_i,
  input  wire                  out_stall_i,
  input  out_item_t            out_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam logic signed [63:0] LIM_HI = 64'sd140737488355327;
  localparam logic signed [63:0] LIM_LO = -64'sd140737488355328;

  logic [46:0] start_price_q, start_var_q;
  logic signed [31:0] drift_q, alpha_q, lambda_q, sigv_q;
  logic signed [25:0] rho_q;
  logic [30:0] dt_q;
  logic signed [63:0] price_q, var_q;
  out_item_t step_results[$];

  function automatic logic signed [63:0] clip(logic signed [127:0] v);
    if (v > 128'(LIM_HI)) return LIM_HI;
    if (v < 128'(LIM_LO)) return LIM_LO;
    return 64'(v);
  endfunction

  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] m;
    logic neg;
    neg = (a < 0) != (b < 0);
    m = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    m = (m + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return clip(neg ? -$signed(m) : $signed(m));
  endfunction

  function automatic logic signed [63:0] fx_add(logic signed [63:0] a, logic signed [63:0] b);
    return clip(128'(a) + 128'(b));
  endfunction

  // floor root of v scaled by 2^FRAC_BITS; non-positive gives zero
  function automatic logic signed [63:0] fx_root(logic signed [63:0] v);
    logic [127:0] rad, cand;
    logic [63:0] r;
    if (v <= 0) return 0;
    rad = 128'(v) << FRAC_BITS;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = 128'(r | (64'd1 << b));
      if (cand * cand <= rad) r = r | (64'd1 << b);
    end
    if (r > 64'(LIM_HI)) r = 64'(LIM_HI);
    return $signed(r);
  endfunction

  function automatic out_item_t euler_step(in_item_t it);
    logic signed [63:0] p, v, s, c, t, mix, np, nv, rho, dw1, dw2;
    out_item_t o;
    if (it.start_path) begin
      price_q = clip(128'(start_price_q));
      var_q = clip(128'(start_var_q));
    end
    p = price_q;
    v = var_q;
    rho = rho_q;
    dw1 = it.dw_price;
    dw2 = it.dw_variance;
    s = fx_root(v);
    t = (64'sd1 << FRAC_BITS) - fx_mul(rho, rho);
    c = fx_root(t < 0 ? 64'sd0 : t);
    mix = fx_add(fx_mul(c, dw1), fx_mul(rho, dw2));
    np = fx_add(p, fx_mul(fx_mul(p, drift_q), 64'(dt_q)));
    np = fx_add(np, fx_mul(fx_mul(p, s), mix));
    t = fx_add(alpha_q, -fx_mul(lambda_q, v));
    nv = fx_add(v, fx_mul(t, 64'(dt_q)));
    nv = fx_add(nv, fx_mul(fx_mul(sigv_q, s), dw2));
    price_q = np;
    var_q = nv;
    o.price = np[47:0];
    o.variance = nv[47:0];
    o.variance_clamped = v < 0;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  assign pending_o = step_results.size();

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      start_price_q <= '0; start_var_q <= '0;
      drift_q <= '0; alpha_q <= '0; lambda_q <= '0; sigv_q <= '0;
      rho_q <= '0; dt_q <= '0;
      price_q = 0; var_q = 0;
      step_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_START_PRICE:    start_price_q <= cfg_data_i;
          CFG_START_VARIANCE: start_var_q <= cfg_data_i;
          CFG_DRIFT_RATE:     drift_q <= cfg_data_i[31:0];
          CFG_REV_LEVEL:      alpha_q <= cfg_data_i[31:0];
          CFG_REV_SPEED:      lambda_q <= cfg_data_i[31:0];
          CFG_VOL_OF_VOL:     sigv_q <= cfg_data_i[31:0];
          CFG_CORRELATION:    rho_q <= cfg_data_i[25:0];
          CFG_STEP_SIZE:      dt_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) step_results.push_back(euler_step(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (step_results.size() == 0) begin
          report_mismatch("unexpected item", 64'(out_data_i.price), 0);
        end else begin
          want = step_results.pop_front();
          if (out_data_i.price !== want.price)
            report_mismatch("price", 64'(out_data_i.price), 64'(want.price));
          if (out_data_i.variance !== want.variance)
            report_mismatch("variance", 64'(out_data_i.variance), 64'(want.variance));
          if (out_data_i.variance_clamped !== want.variance_clamped)
            report_mismatch("clamp flag", 64'(out_data_i.variance_clamped),
                            64'(want.variance_clamped));
        end
      end
    end
  end

endmodule

// File: tb/heston_euler_path_step_test.sv
// Testbench top: drives configuration and path items into the Heston step and gives the verdict.
`timescale 1ns / 100ps
module heston_euler_path_step_test;
  import hes_pkg::*;

  localparam int RANDOM_ITEMS = 1030;
  localparam int ITEM_CYCLES  = 700;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  int                    fail_count;
  int                    pending;
  bit                    stim_done;

  heston_euler_path_step dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  heston_euler_path_step_checker checker_u (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit: every item at full latency plus the longest gaps, taken three times over.
  initial begin
    #(64'd10 * (RANDOM_ITEMS + 200) * (ITEM_CYCLES + 30) * 3);
    $display("heston_euler_path_step_test: FAIL");
    $finish;
  end

  // Write one register; cfg_ready is waited for at each edge. Valid stays up for the next write.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Hold the item until it is taken, then idle for a random gap.
  task automatic send_item(logic start, logic [31:0] dw1, logic [31:0] dw2);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{start_path: start, dw_price: dw1, dw_variance: dw2};
    do @(posedge clk); while (in_stall);
    gap = $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all results and let the block settle before touching registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (ITEM_CYCLES) @(posedge clk);
  endtask

  // Random Q7.24 values weighted towards modest magnitudes so paths stay alive.
  function automatic logic [31:0] small_q();
    case ($urandom_range(0, 3))
      0: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      2: return 32'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic load_params(logic [46:0] sp, logic [46:0] sv, logic [31:0] r,
                             logic [31:0] a, logic [31:0] l, logic [31:0] sg,
                             logic [25:0] rho, logic [30:0] dt);
    write_reg(CFG_START_PRICE, sp);
    write_reg(CFG_START_VARIANCE, sv);
    write_reg(CFG_DRIFT_RATE, 47'(r));
    write_reg(CFG_REV_LEVEL, 47'(a));
    write_reg(CFG_REV_SPEED, 47'(l));
    write_reg(CFG_VOL_OF_VOL, 47'(sg));
    write_reg(CFG_CORRELATION, 47'(rho));
    write_reg(CFG_STEP_SIZE, 47'(dt));
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stall for a random stretch before each result, with calm phases.
  initial begin
    int hold;
    out_stall <= 1'b1;
    @(posedge rst_n);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int sent;
    int steps;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // From reset: zero state, zero parameters; extremes of the increments.
    send_item(1'b0, 32'h7fffffff, 32'h80000000);
    send_item(1'b0, 32'h80000000, 32'h7fffffff);
    wait_idle();

    // Typical path: S=100, V=0.04, r=0.05, rho=-0.7, dt=1/256.
    load_params(47'd100 << 24, 47'd671089, 32'd838861, 32'd1342177, 32'd33554432,
                32'd5033165, -26'sd11744051, 31'd65536);
    send_item(1'b1, 32'h00100000, 32'hfff00000);
    send_item(1'b0, 32'h7fffffff, 32'h7fffffff);
    send_item(1'b0, 32'h80000000, 32'h80000000);
    send_item(1'b0, 32'h00000000, 32'h00000000);
    wait_idle();

    // Variance driven negative: clamped root, lambda term on negative variance.
    load_params(47'd1 << 24, 47'd1000, 32'd0, 32'h80000000, 32'h7fffffff,
                32'h7fffffff, 26'sd16777216, 31'h7fffffff);
    send_item(1'b1, 32'h01000000, 32'h80000000);
    send_item(1'b0, 32'h01000000, 32'h01000000);
    send_item(1'b0, 32'hff000000, 32'h7fffffff);
    wait_idle();

    // Register extremes: start values at the top of the state range, rho beyond one, max drift.
    load_params('1, '1, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                32'h80000000, 26'h2000000, 31'h7fffffff);
    send_item(1'b1, 32'h7fffffff, 32'h80000000);
    send_item(1'b0, 32'h12345678, 32'h87654321);
    send_item(1'b1, 32'h80000000, 32'h7fffffff);
    wait_idle();
    load_params('0, '1, 32'h80000000, 32'h0, 32'h0, 32'h7fffffff, 26'h1ffffff, 31'h0);
    send_item(1'b1, 32'hffffffff, 32'hffffffff);
    send_item(1'b0, 32'h55555555, 32'haaaaaaaa);
    wait_idle();

    // Random phases: new parameters, then restarted paths of random length.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      load_params(($urandom_range(0, 7) == 0) ? 47'({$urandom, $urandom})
                    : 47'($urandom_range(0, 1 << 30)) << 2,
                  ($urandom_range(0, 7) == 0) ? 47'({$urandom, $urandom})
                    : 47'($urandom_range(0, 1 << 24)),
                  small_q(), small_q(), small_q(), small_q(),
                  ($urandom_range(0, 9) == 0) ? 26'($urandom)
                    : 26'($signed($urandom_range(0, 1 << 25)) - (1 << 24)),
                  ($urandom_range(0, 5) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20)));
      repeat ($urandom_range(1, 4)) begin
        steps = $urandom_range(1, 30);
        send_item(1'b1, small_q(), small_q());
        sent++;
        for (int k = 1; k < steps; k++) begin
          send_item($urandom_range(0, 19) == 0, small_q(), small_q());
          sent++;
        end
      end
      wait_idle();
    end

    stim_done = 1'b1;
  end

  // Verdict once stimulus is finished and the checker holds nothing.
  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (ITEM_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("heston_euler_path_step_test: PASS");
    else
      $display("heston_euler_path_step_test: FAIL");
    $finish;
  end

endmodule

// File: sim.f
sv/hes_pkg.sv
sv/hes_unit.sv
sv/heston_euler_path_step.sv
tb/heston_euler_path_step_checker.sv
tb/heston_euler_path_step_test.sv
